// ===== hw/rtl/device_reboot_sequencer_core_macros.svh =====
// assertion macros for the reboot sequencer
`ifndef DEVICE_REBOOT_SEQUENCER_CORE_MACROS_SVH
`define DEVICE_REBOOT_SEQUENCER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DRS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define DRS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define DRS_ASSERT(label, prop)
`define DRS_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ===== hw/rtl/drs_pkg.sv =====
package drs_pkg;

  localparam int unsigned CfgWidth   = 10;
  localparam int unsigned RetryWidth = 9;
  localparam int unsigned LimitWidth = 8;
  localparam int unsigned StatWidth  = 4;

  localparam int unsigned StPower   = 0;
  localparam int unsigned StReady   = 1;
  localparam int unsigned StInhibit = 2;
  localparam int unsigned StReprint = 3;

  localparam logic [CfgWidth-1:0]   PowerdownTicksRst = 10'd50;
  localparam logic [CfgWidth-1:0]   BootWaitTicksRst  = 10'd250;
  localparam logic [CfgWidth-1:0]   ResetTicksRst     = 10'd25;
  localparam logic [CfgWidth-1:0]   ReadyWaitTicksRst = 10'd25;
  localparam logic [LimitWidth-1:0] RetryLimitRst     = 8'd12;

  localparam logic [RetryWidth-1:0] RetryMax = '1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_POWERDOWN = 3'd1,
    PH_WAITBOOT  = 3'd2,
    PH_RESET     = 3'd3,
    PH_WAITREADY = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    CFG_POWERDOWN_TICKS  = 3'd0,
    CFG_BOOT_WAIT_TICKS  = 3'd1,
    CFG_RESET_TICKS      = 3'd2,
    CFG_READY_WAIT_TICKS = 3'd3,
    CFG_RETRY_LIMIT      = 3'd4
  } cfg_reg_e;

endpackage

// ===== hw/rtl/device_reboot_sequencer_core.sv =====
// device reboot sequencer core
// one input item is one control pass: an optional tick, the sensed powered,
// ready and disabled flags, a reboot request and a status-sent flag. every
// item gives exactly one result item: the status bits, the sequencer phase
// after the pass, a reprint pulse and the retries counted so far.
// the input channel has a one-item input register; the pass is computed
// from it into the output register, which offers the result on the output
// channel. throughput is one item per cycle while the receiver takes the
// results; the pass state (status word, phase, wait counter, retry
// counter) is updated in the same cycle the result is registered, so the
// next item sees it straight away.
// when the receiver stalls, the result is held and one more item waits in
// the input register; after that tready drops until the result is taken.
// the configuration channel is always ready; write only while idle.
// reset clears the state to idle and loads the default register values:
// 50, 250, 25, 25 ticks and a retry limit of 12.
`include "device_reboot_sequencer_core_macros.svh"

module device_reboot_sequencer_core
  import drs_pkg::*;
#(
  parameter int unsigned WAIT_WIDTH = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tick, powered, ready_req, disabled, reboot_request, status_sent, zero pad
  input  logic [7:0]          s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // stat_power, stat_ready, stat_inhibit, stat_reprint, phase[2:0],
  // reprint_pulse, retries_done[8:0], zero pad
  output logic [23:0]         m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  localparam int unsigned CmpWidth = (WAIT_WIDTH > CfgWidth) ? WAIT_WIDTH : CfgWidth;
  localparam logic [CmpWidth-1:0] WaitMax = CmpWidth'((64'd1 << WAIT_WIDTH) - 64'd1);

  function automatic logic [WAIT_WIDTH-1:0] load_wait(input logic [CfgWidth-1:0] ticks);
    logic [CmpWidth-1:0] ext;
    ext = CmpWidth'(ticks);
    if (ext > WaitMax) begin
      ext = WaitMax;
    end
    return ext[WAIT_WIDTH-1:0];
  endfunction

  // configuration
  logic [CfgWidth-1:0]   powerdown_ticks_q, boot_wait_ticks_q, reset_ticks_q;
  logic [CfgWidth-1:0]   ready_wait_ticks_q;
  logic [LimitWidth-1:0] retry_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powerdown_ticks_q  <= PowerdownTicksRst;
      boot_wait_ticks_q  <= BootWaitTicksRst;
      reset_ticks_q      <= ResetTicksRst;
      ready_wait_ticks_q <= ReadyWaitTicksRst;
      retry_limit_q      <= RetryLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_POWERDOWN_TICKS:  powerdown_ticks_q  <= cfg_data_i;
        CFG_BOOT_WAIT_TICKS:  boot_wait_ticks_q  <= cfg_data_i;
        CFG_RESET_TICKS:      reset_ticks_q      <= cfg_data_i;
        CFG_READY_WAIT_TICKS: ready_wait_ticks_q <= cfg_data_i;
        CFG_RETRY_LIMIT:      retry_limit_q      <= cfg_data_i[LimitWidth-1:0];
        default: ;
      endcase
    end
  end

  // input register and output register handshake
  logic       in_valid_q;
  logic [5:0] in_data_q;
  logic       out_valid_q;
  logic [16:0] out_data_q, out_data_d;
  logic       advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i[5:0];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // pass state
  logic [StatWidth-1:0]  stored_status_q, stored_status_d;
  phase_e                seq_phase_q, seq_phase_d;
  logic [WAIT_WIDTH-1:0] wait_count_q, wait_count_d;
  logic [RetryWidth-1:0] retry_count_q, retry_count_d;
  logic                  reprint_pending_q, reprint_pending_d;

  logic                  tick, powered, ready_req, disabled, reboot_request, status_sent;
  logic [StatWidth-1:0]  st;
  logic [WAIT_WIDTH-1:0] wait_dec;
  logic [RetryWidth-1:0] retry_inc;

  assign tick           = in_data_q[0];
  assign powered        = in_data_q[1];
  assign ready_req      = in_data_q[2];
  assign disabled       = in_data_q[3];
  assign reboot_request = in_data_q[4];
  assign status_sent    = in_data_q[5];

  always_comb begin
    wait_dec = wait_count_q;
    if (tick && (wait_count_q != '0)) begin
      wait_dec = wait_count_q - 1'b1;
    end

    st = '0;
    st[StInhibit] = stored_status_q[StInhibit];
    if (powered) begin
      st[StPower] = 1'b1;
      if (!stored_status_q[StPower] && (seq_phase_q == PH_IDLE)) begin
        st[StInhibit] = 1'b1;
      end
    end
    if (ready_req) begin
      st[StReady]   = 1'b1;
      st[StInhibit] = 1'b0;
    end
    if (disabled) begin
      st[StInhibit] = 1'b1;
    end
    st[StReprint] = stored_status_q[StReprint] | reprint_pending_q;

    stored_status_d = st;
    if (status_sent) begin
      stored_status_d[StReprint] = 1'b0;
    end

    retry_inc = (retry_count_q < RetryMax) ? retry_count_q + 1'b1 : retry_count_q;

    reprint_pending_d = 1'b0;
    seq_phase_d       = seq_phase_q;
    wait_count_d      = wait_dec;
    retry_count_d     = retry_count_q;
    if (reboot_request && (seq_phase_q == PH_IDLE) && !st[StInhibit]) begin
      wait_count_d  = load_wait(powerdown_ticks_q);
      seq_phase_d   = PH_POWERDOWN;
      retry_count_d = '0;
    end else if (wait_dec == '0) begin
      case (seq_phase_q)
        PH_POWERDOWN: begin
          wait_count_d = load_wait(boot_wait_ticks_q);
          seq_phase_d  = PH_WAITBOOT;
        end
        PH_WAITBOOT: begin
          wait_count_d = load_wait(reset_ticks_q);
          seq_phase_d  = PH_RESET;
        end
        PH_RESET: begin
          wait_count_d = load_wait(ready_wait_ticks_q);
          seq_phase_d  = PH_WAITREADY;
        end
        PH_WAITREADY: begin
          if (st[StReady]) begin
            reprint_pending_d = 1'b1;
            seq_phase_d       = PH_IDLE;
          end else begin
            retry_count_d = retry_inc;
            if (retry_inc <= RetryWidth'(retry_limit_q)) begin
              wait_count_d = load_wait(boot_wait_ticks_q);
              seq_phase_d  = PH_WAITBOOT;
            end else begin
              seq_phase_d = PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end

    out_data_d = {retry_count_d, reprint_pending_d, 3'(seq_phase_d), st};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_status_q   <= '0;
      seq_phase_q       <= PH_IDLE;
      wait_count_q      <= '0;
      retry_count_q     <= '0;
      reprint_pending_q <= 1'b0;
    end else if (advance) begin
      stored_status_q   <= stored_status_d;
      seq_phase_q       <= seq_phase_d;
      wait_count_q      <= wait_count_d;
      retry_count_q     <= retry_count_d;
      reprint_pending_q <= reprint_pending_d;
    end
  end

  `DRS_ASSERT(a_pulse_only_idle, !reprint_pending_q || (seq_phase_q == PH_IDLE))
  `DRS_ASSERT(a_idle_wait_zero, (seq_phase_q != PH_IDLE) || (wait_count_q == '0))
  `DRS_ASSERT_NEXT(a_result_registered, advance, out_valid_q)

endmodule
